### src/mrs_pkg.sv
// Shared types, constants and helpers for the magnetometer reading block.
package mrs_pkg;

  localparam int SAMPLE_WIDTH = 16;
  // Width of the rounded sum before saturation; must hold SAMPLE_WIDTH+1 bits.
  localparam int SUM_W = (SAMPLE_WIDTH > 23) ? SAMPLE_WIDTH + 1 : 24;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_EARTH_FIELD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_ROW_ZERO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_ROW_ONE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_ROW_TWO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_OFFSETS = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROD,
    OP_SUMD,
    OP_DINIT,
    OP_DSTEP,
    OP_DDONE,
    OP_ROT,
    OP_CAL,
    OP_RND,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] sel;
    logic [1:0] i;
    logic [1:0] j;
    logic [3:0] k;
  } cmd_t;

  typedef struct packed {
    logic zero_d;
  } status_t;

  function automatic logic signed [15:0] lane(input logic [47:0] word, input logic [1:0] idx);
    logic signed [15:0] r;
    case (idx)
      2'd0: r = word[15:0];
      2'd1: r = word[31:16];
      2'd2: r = word[47:32];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/mrs_ctrl.sv
// Sequencer for the magnetometer reading block: issues one datapath command per cycle.
module mrs_ctrl import mrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    slot_free,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_SUMD, S_CHECK, S_DINIT, S_DSTEP, S_DDONE, S_ROT, S_CAL, S_RND, S_WAIT
  } state_t;

  state_t     state;
  logic [3:0] cnt;
  logic [3:0] k;
  logic [1:0] i;
  logic [1:0] j;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.op = OP_NONE;
    cmd.sel = cnt;
    cmd.i = i;
    cmd.j = j;
    cmd.k = k;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_PROD:  cmd.op = OP_PROD;
      S_SUMD:  cmd.op = OP_SUMD;
      S_DINIT: cmd.op = OP_DINIT;
      S_DSTEP: cmd.op = OP_DSTEP;
      S_DDONE: cmd.op = OP_DDONE;
      S_ROT:   cmd.op = OP_ROT;
      S_CAL:   cmd.op = OP_CAL;
      S_RND:   cmd.op = OP_RND;
      S_WAIT:  cmd.op = slot_free ? OP_EMIT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      k <= '0;
      i <= '0;
      j <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PROD;
            cnt <= '0;
          end
        end
        S_PROD: begin
          if (cnt == 4'd9) begin
            state <= S_SUMD;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_SUMD: state <= S_CHECK;
        S_CHECK: begin
          cnt <= '0;
          state <= status.zero_d ? S_WAIT : S_DINIT;
        end
        S_DINIT: begin
          k <= 4'd14;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          if (k == 4'd0) begin
            state <= S_DDONE;
          end else begin
            k <= k - 4'd1;
          end
        end
        S_DDONE: begin
          if (cnt == 4'd8) begin
            i <= '0;
            j <= '0;
            state <= S_ROT;
          end else begin
            cnt <= cnt + 4'd1;
            state <= S_DINIT;
          end
        end
        S_ROT: begin
          if (j == 2'd2) begin
            j <= '0;
            if (i == 2'd2) begin
              i <= '0;
              state <= S_CAL;
            end else begin
              i <= i + 2'd1;
            end
          end else begin
            j <= j + 2'd1;
          end
        end
        S_CAL: begin
          if (j == 2'd2) begin
            state <= S_RND;
          end else begin
            j <= j + 2'd1;
          end
        end
        S_RND: begin
          j <= '0;
          if (i == 2'd2) begin
            state <= S_WAIT;
          end else begin
            i <= i + 2'd1;
            state <= S_CAL;
          end
        end
        S_WAIT: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/mrs_datapath.sv
// Datapath: quaternion products, iterative matrix-entry divider, rotation and calibration MACs.
module mrs_datapath import mrs_pkg::*; (
  input  logic                           clk,
  input  cmd_t                           cmd,
  input  logic signed [15:0]             quat_x,
  input  logic signed [15:0]             quat_y,
  input  logic signed [15:0]             quat_z,
  input  logic signed [15:0]             quat_w,
  input  logic [47:0]                    earth_field,
  input  logic [47:0]                    cal_row_zero,
  input  logic [47:0]                    cal_row_one,
  input  logic [47:0]                    cal_row_two,
  input  logic [47:0]                    bias_offsets,
  output status_t                        status,
  output logic signed [SAMPLE_WIDTH-1:0] res_x,
  output logic signed [SAMPLE_WIDTH-1:0] res_y,
  output logic signed [SAMPLE_WIDTH-1:0] res_z
);

  localparam int REM_W = 50;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] prod [10];
  logic [32:0]        d;
  logic [REM_W-1:0]   rem;
  logic [14:0]        quo;
  logic               neg;
  logic signed [14:0] m [9];
  logic signed [31:0] v [3];
  logic signed [47:0] acc;

  // product operands
  logic signed [15:0] pa, pb;
  always_comb begin
    case (cmd.sel)
      4'd0: begin pa = qx; pb = qx; end
      4'd1: begin pa = qy; pb = qy; end
      4'd2: begin pa = qz; pb = qz; end
      4'd3: begin pa = qw; pb = qw; end
      4'd4: begin pa = qx; pb = qy; end
      4'd5: begin pa = qx; pb = qz; end
      4'd6: begin pa = qy; pb = qz; end
      4'd7: begin pa = qw; pb = qx; end
      4'd8: begin pa = qw; pb = qy; end
      default: begin pa = qw; pb = qz; end
    endcase
  end

  // rotation numerator for entry sel = row*3+col
  logic signed [35:0] ds, n, pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  always_comb begin
    ds  = 36'(signed'({3'b0, d}));
    pxx = 36'(prod[0]);
    pyy = 36'(prod[1]);
    pzz = 36'(prod[2]);
    pxy = 36'(prod[4]);
    pxz = 36'(prod[5]);
    pyz = 36'(prod[6]);
    pwx = 36'(prod[7]);
    pwy = 36'(prod[8]);
    pwz = 36'(prod[9]);
    case (cmd.sel)
      4'd0: n = ds - ((pyy + pzz) <<< 1);
      4'd1: n = (pxy - pwz) <<< 1;
      4'd2: n = (pxz + pwy) <<< 1;
      4'd3: n = (pxy + pwz) <<< 1;
      4'd4: n = ds - ((pxx + pzz) <<< 1);
      4'd5: n = (pyz - pwx) <<< 1;
      4'd6: n = (pxz - pwy) <<< 1;
      4'd7: n = (pyz + pwx) <<< 1;
      default: n = ds - ((pxx + pyy) <<< 1);
    endcase
  end

  logic [33:0]              den;
  logic signed [REM_W-1:0]  num;
  logic [REM_W-1:0]         trial;
  assign den   = {d, 1'b0};
  assign num   = (REM_W'(n) <<< 14) + REM_W'(signed'({17'b0, d}));
  assign trial = REM_W'(den) << cmd.k;

  // multiply-accumulate operands
  logic [3:0]         mi;
  logic signed [30:0] rot_p;
  logic signed [15:0] cal_c;
  logic [47:0]        cal_row;
  logic signed [47:0] cal_p;
  assign mi    = 4'({cmd.j, 1'b0}) + 4'(cmd.j) + 4'(cmd.i);
  assign rot_p = m[mi] * lane(earth_field, cmd.j);
  always_comb begin
    case (cmd.i)
      2'd0: cal_row = cal_row_zero;
      2'd1: cal_row = cal_row_one;
      default: cal_row = cal_row_two;
    endcase
  end
  assign cal_c = lane(cal_row, cmd.j);
  assign cal_p = cal_c * v[cmd.j];

  // round to counts, add bias, saturate
  logic signed [21:0]      rnd;
  logic signed [SUM_W-1:0] rsum;
  logic signed [SAMPLE_WIDTH-1:0] sat;
  assign rnd  = 22'((acc + 48'sd33554432) >>> 26);
  assign rsum = SUM_W'(rnd) + SUM_W'(lane(bias_offsets, cmd.i));
  always_comb begin
    if (rsum > SAT_HI) sat = SAT_HI[SAMPLE_WIDTH-1:0];
    else if (rsum < SAT_LO) sat = SAT_LO[SAMPLE_WIDTH-1:0];
    else sat = rsum[SAMPLE_WIDTH-1:0];
  end

  assign status.zero_d = (d == '0);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        qx <= quat_x;
        qy <= quat_y;
        qz <= quat_z;
        qw <= quat_w;
      end
      OP_PROD: prod[cmd.sel] <= pa * pb;
      OP_SUMD: d <= 33'(prod[0]) + 33'(prod[1]) + 33'(prod[2]) + 33'(prod[3]);
      OP_DINIT: begin
        neg <= num[REM_W-1];
        quo <= '0;
        if (num[REM_W-1]) rem <= REM_W'(-num) + REM_W'(den) - REM_W'(1);
        else rem <= num;
      end
      OP_DSTEP: begin
        if (rem >= trial) begin
          rem <= rem - trial;
          quo[cmd.k] <= 1'b1;
        end
      end
      OP_DDONE: m[cmd.sel] <= neg ? -signed'(quo) : signed'(quo);
      OP_ROT: begin
        if (cmd.j == 2'd0) v[cmd.i] <= 32'(rot_p);
        else v[cmd.i] <= v[cmd.i] + 32'(rot_p);
      end
      OP_CAL: begin
        if (cmd.j == 2'd0) acc <= cal_p;
        else acc <= acc + cal_p;
      end
      OP_RND: begin
        case (cmd.i)
          2'd0: res_x <= sat;
          2'd1: res_y <= sat;
          default: res_z <= sat;
        endcase
      end
      default: ;
    endcase
  end

endmodule

### src/magnetometer_reading_synth.sv
// Top level of the simulated magnetometer reading block.
//
//  channel | signals                                   | role
//  in      | in_valid/in_ready, quat_x..quat_w         | attitude quaternion
//  out     | out_valid/out_ready, field_*, sample_number, zero_quat_flag | reading
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register writes
//
// From acceptance to result, an item goes through ten products on one 16x16
// multiplier, then nine matrix entries through a one-bit-per-cycle restoring
// divider, then the rotation and calibration/rounding MACs on single multipliers;
// a zero quaternion skips the divider, rotation and calibration. The next item is
// accepted once the result has moved to the output register. Reset is synchronous;
// stalls on out_ready hold the output register.
module magnetometer_reading_synth import mrs_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             quat_x,
  input  logic signed [15:0]             quat_y,
  input  logic signed [15:0]             quat_z,
  input  logic signed [15:0]             quat_w,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] field_x,
  output logic signed [SAMPLE_WIDTH-1:0] field_y,
  output logic signed [SAMPLE_WIDTH-1:0] field_z,
  output logic [31:0]                    sample_number,
  output logic                           zero_quat_flag,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [47:0]                    cfg_data
);

  logic [47:0] earth_field, cal_row_zero, cal_row_one, cal_row_two, bias_offsets;
  logic [31:0] reading_counter;
  logic [31:0] sample_hold;
  cmd_t        cmd;
  status_t     status;
  logic        slot_free;
  logic signed [SAMPLE_WIDTH-1:0] res_x, res_y, res_z;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_field <= '0;
      cal_row_zero <= 48'h0000_0000_2000;
      cal_row_one <= 48'h0000_2000_0000;
      cal_row_two <= 48'h2000_0000_0000;
      bias_offsets <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EARTH_FIELD:  earth_field <= cfg_data;
        REG_CAL_ROW_ZERO: cal_row_zero <= cfg_data;
        REG_CAL_ROW_ONE:  cal_row_one <= cfg_data;
        REG_CAL_ROW_TWO:  cal_row_two <= cfg_data;
        REG_BIAS_OFFSETS: bias_offsets <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_counter <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reading_counter <= reading_counter + 32'd1;
        sample_hold <= reading_counter;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
        zero_quat_flag <= status.zero_d;
        sample_number <= sample_hold;
        field_x <= status.zero_d ? '0 : res_x;
        field_y <= status.zero_d ? '0 : res_y;
        field_z <= status.zero_d ? '0 : res_z;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  mrs_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .slot_free(slot_free),
    .status(status),
    .cmd(cmd)
  );

  mrs_datapath u_dp (
    .clk(clk),
    .cmd(cmd),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z),
    .quat_w(quat_w),
    .earth_field(earth_field),
    .cal_row_zero(cal_row_zero),
    .cal_row_one(cal_row_one),
    .cal_row_two(cal_row_two),
    .bias_offsets(bias_offsets),
    .status(status),
    .res_x(res_x),
    .res_y(res_y),
    .res_z(res_z)
  );

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_quat_flag |-> field_x == '0 && field_y == '0 && field_z == '0)
    else $error("zero quaternion reading has nonzero field");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in flight");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> reading_counter == $past(reading_counter) + 32'd1)
    else $error("sample counter did not advance on accept");

endmodule
